// ===== src/mpq_pkg.sv =====
package mpq_pkg;

	// Heap depth and the field widths of the queue.
	localparam int CAPACITY = 64;
	localparam int KEY_W    = 32;
	localparam int ENTRY_W  = 7;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// Child indexes of the deepest node reach twice the capacity.
	localparam int CH_W     = IDX_W + 2;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_FIND    = 2'd1,
		OP_EXTRACT = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Finished result handed from the sequencer to the output register.
	typedef struct packed {
		logic [KEY_W-1:0]   min_value;
		logic [1:0]         status;
		logic [ENTRY_W-1:0] entry_count;
	} result_t;

endpackage

// ===== src/mpq_ram.sv =====
module mpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/mpq_seq.sv =====
module mpq_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             opcode,
	input  logic [mpq_pkg::KEY_W-1:0] key_value,
	output logic                   res_valid,
	input  logic                   res_take,
	output mpq_pkg::result_t       res
);

	import mpq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MIN_WAIT,
		S_LAST_WAIT,
		S_UP_CHK,
		S_UP_CMP,
		S_DN_CHK,
		S_DN_RDR,
		S_DN_CMP,
		S_FIN
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   pos_q;
	logic [KEY_W-1:0]   val_q;
	logic [KEY_W-1:0]   lval_q;
	logic               rok_q;
	logic               extract_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [KEY_W-1:0]   min_q;
	logic [1:0]         status_q;

	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic [KEY_W-1:0]   wdata;
	logic [IDX_W-1:0]   raddr;
	logic [KEY_W-1:0]   rdata;

	logic [CH_W-1:0]    left_idx;
	logic [CH_W-1:0]    right_idx;
	logic [CH_W-1:0]    cnt_ext;
	logic [IDX_W-1:0]   parent_idx;
	logic               left_ok;
	logic               right_ok;
	logic               parent_le;
	logic               pick_right;
	logic [KEY_W-1:0]   child_val;
	logic [IDX_W-1:0]   child_idx;
	logic               child_lt;
	logic               accept;

	mpq_ram #(
		.WIDTH(KEY_W),
		.DEPTH(CAPACITY)
	) u_heap (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res       = '{min_value: min_q, status: status_q,
		entry_count: ENTRY_W'(cnt_q)};

	// Heap index arithmetic for the current hole position.
	assign left_idx   = {1'b0, pos_q, 1'b1};
	assign right_idx  = left_idx + CH_W'(1);
	assign cnt_ext    = CH_W'(cnt_q);
	assign left_ok    = left_idx < cnt_ext;
	assign right_ok   = right_idx < cnt_ext;
	assign parent_idx = IDX_W'((pos_q - IDX_W'(1)) >> 1);

	// Signed comparators: parent against the rising value, and the smaller
	// child against the sinking value.
	assign parent_le  = $signed(rdata) <= $signed(val_q);
	assign pick_right = rok_q && ($signed(rdata) < $signed(lval_q));
	assign child_val  = pick_right ? rdata : lval_q;
	assign child_idx  = pick_right ? IDX_W'(left_idx + CH_W'(1)) : IDX_W'(left_idx);
	assign child_lt   = $signed(child_val) < $signed(val_q);

	// Memory port control per sequencer step.
	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = val_q;
		raddr = '0;
		case (state_q)
			S_MIN_WAIT: begin
				raddr = IDX_W'(cnt_q - CNT_W'(1));
			end
			S_UP_CHK: begin
				raddr = parent_idx;
				we    = (pos_q == '0);
			end
			S_UP_CMP: begin
				we    = 1'b1;
				wdata = parent_le ? val_q : rdata;
			end
			S_DN_CHK: begin
				raddr = IDX_W'(left_idx);
				we    = !left_ok;
			end
			S_DN_RDR: begin
				raddr = IDX_W'(right_idx);
			end
			S_DN_CMP: begin
				we    = 1'b1;
				wdata = child_lt ? child_val : val_q;
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	// Sequencer state and held result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			pos_q     <= '0;
			val_q     <= '0;
			lval_q    <= '0;
			rok_q     <= 1'b0;
			extract_q <= 1'b0;
			min_q     <= '0;
			status_q  <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						min_q     <= '0;
						status_q  <= ST_OK;
						extract_q <= (opcode == OP_EXTRACT);
						val_q     <= key_value;
						case (opcode)
							OP_INSERT: begin
								if (cnt_q >= CNT_W'(CAPACITY)) begin
									status_q <= ST_FULL;
									state_q  <= S_FIN;
								end else begin
									pos_q   <= IDX_W'(cnt_q);
									cnt_q   <= cnt_q + CNT_W'(1);
									state_q <= S_UP_CHK;
								end
							end
							OP_FIND, OP_EXTRACT: begin
								if (cnt_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_FIN;
								end else begin
									state_q <= S_MIN_WAIT;
								end
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_MIN_WAIT: begin
					// Root is on the read port; an extract also fetches the last entry.
					min_q <= rdata;
					if (extract_q) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_LAST_WAIT;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_LAST_WAIT: begin
					val_q   <= rdata;
					pos_q   <= '0;
					state_q <= S_DN_CHK;
				end
				S_UP_CHK: begin
					state_q <= (pos_q == '0) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (parent_le) begin
						state_q <= S_FIN;
					end else begin
						pos_q   <= parent_idx;
						state_q <= S_UP_CHK;
					end
				end
				S_DN_CHK: begin
					state_q <= left_ok ? S_DN_RDR : S_FIN;
				end
				S_DN_RDR: begin
					lval_q  <= rdata;
					rok_q   <= right_ok;
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (child_lt) begin
						pos_q   <= child_idx;
						state_q <= S_DN_CHK;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/min_priority_queue.sv =====
// Min-priority queue of signed 32-bit keys held as a binary min-heap in a
// 64-entry RAM with one read and one write port. Each transaction carries an
// insert, find-minimum or extract-minimum operation and yields exactly one
// result transaction with the minimum (zero unless a find or extract found
// one), a status (ok, empty, or full with the insert dropped) and the entry
// count after the operation. One operation is in flight at a time. An insert
// sifts up with a check and a compare step per level, and an extract sifts
// down with a check, a right-child read and a compare step per level, since
// both children pass through the single RAM read port. A new transaction is
// taken while the previous result still waits in the output register.
module min_priority_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                opcode,
	input  logic [mpq_pkg::KEY_W-1:0] key_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [mpq_pkg::KEY_W-1:0] min_value,
	output logic [1:0]                status,
	output logic [mpq_pkg::ENTRY_W-1:0] entry_count
);

	import mpq_pkg::*;

	logic    res_valid;
	logic    res_take;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	mpq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.key_value(key_value),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res)
	);

	// Output register: loads a finished result whenever it is free or draining.
	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign min_value   = out_q.min_value;
	assign status      = out_q.status;
	assign entry_count = out_q.entry_count;

	// An accepted operation leaves the queue busy in the cycle after it is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("queue ready right after accepting an operation");

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= ENTRY_W'(CAPACITY))
		else $error("entry count above capacity");

	// A dropped insert only happens on a full queue.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == ENTRY_W'(CAPACITY)
			&& min_value == '0)
		else $error("full status with room left");

	// An empty result reports an empty queue and a zero minimum.
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> entry_count == '0 && min_value == '0)
		else $error("empty status on a non-empty queue");

endmodule
